### sv/fca_pkg.sv
package fca_pkg;

   localparam int NUM_CLUSTERS_DEFAULT = 4096;

   localparam int FUNC_W    = 2;
   localparam int CLUSTER_W = 28;
   localparam int STATUS_W  = 3;
   localparam int DCC_W     = 12;
   localparam int CSR_IDX_W = 1;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_FREE = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_IO      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_CORRUPT = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_CLUSTER_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_OF_CHAIN       = 1'd1;

   localparam logic [DCC_W-1:0]     DCC_RESET = 12'd4094;
   localparam logic [CLUSTER_W-1:0] EOC_RESET = 28'd268435448;

   typedef struct packed {
      logic [DCC_W-1:0]     data_cluster_count;
      logic [CLUSTER_W-1:0] end_of_chain_value;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [CLUSTER_W-1:0] cluster;
      logic [STATUS_W-1:0]  status;
   } res_type;

endpackage

### sv/fca_ram.sv
module fca_ram #(
   parameter int DEPTH = fca_pkg::NUM_CLUSTERS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [fca_pkg::CLUSTER_W-1:0]    wdata,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [fca_pkg::CLUSTER_W-1:0]    rdata
);

   logic [fca_pkg::CLUSTER_W-1:0] mem [DEPTH];
   logic [fca_pkg::CLUSTER_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // write-first: a read of the address being written sees the new data
   always_ff @(posedge clock) begin
      if (we && (waddr == raddr)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/fca_ctrl.sv
module fca_ctrl #(
   parameter int NUM_CLUSTERS = fca_pkg::NUM_CLUSTERS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fca_pkg::FUNC_W-1:0]          req_func,
   input  logic [fca_pkg::CLUSTER_W-1:0]       req_cluster,
   input  logic [fca_pkg::CLUSTER_W-1:0]       req_entry_value,
   input  fca_pkg::cfg_type                    cfg,
   output fca_pkg::res_type                    res,
   input  logic                                res_take,
   output logic                                mem_we,
   output logic [$clog2(NUM_CLUSTERS)-1:0]     mem_waddr,
   output logic [fca_pkg::CLUSTER_W-1:0]       mem_wdata,
   output logic [$clog2(NUM_CLUSTERS)-1:0]     mem_raddr,
   input  logic [fca_pkg::CLUSTER_W-1:0]       mem_rdata
);

   localparam int AW = $clog2(NUM_CLUSTERS);
   localparam int CW = (AW + 1 > fca_pkg::DCC_W + 1) ? AW + 1 : fca_pkg::DCC_W + 1;
   localparam logic [CW-1:0] N_CW = CW'(NUM_CLUSTERS);
   localparam logic [CW-1:0] N_LAST = CW'(NUM_CLUSTERS - 1);
   localparam logic [fca_pkg::CLUSTER_W-1:0] N_CL = fca_pkg::CLUSTER_W'(NUM_CLUSTERS);
   localparam logic [fca_pkg::CLUSTER_W-1:0] TWO_CL = 28'd2;

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_SCAN     = 3'd2;
   localparam logic [2:0] ST_LINK     = 3'd3;
   localparam logic [2:0] ST_WALK_CHK = 3'd4;
   localparam logic [2:0] ST_WALK     = 3'd5;
   localparam logic [2:0] ST_RD_WAIT  = 3'd6;
   localparam logic [2:0] ST_RESULT   = 3'd7;

   logic [2:0]                       state_ff, state_in;
   logic [CW-1:0]                    scan_ff, scan_in;
   logic [CW-1:0]                    chk_ff, chk_in;
   logic                             chk_valid_ff, chk_valid_in;
   logic [fca_pkg::CLUSTER_W-1:0]    cur_ff, cur_in;
   logic [fca_pkg::CLUSTER_W-1:0]    prev_ff, prev_in;
   logic [fca_pkg::CLUSTER_W-1:0]    res_cluster_ff, res_cluster_in;
   logic [fca_pkg::STATUS_W-1:0]     res_status_ff, res_status_in;

   logic [CW-1:0]                    last;
   logic                             accept;
   logic                             link_req;

   assign last      = CW'(cfg.data_cluster_count) + CW'(1);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign link_req  = (prev_ff >= TWO_CL);

   assign res.valid   = (state_ff == ST_RESULT);
   assign res.cluster = res_cluster_ff;
   assign res.status  = res_status_ff;

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      chk_in         = chk_ff;
      chk_valid_in   = chk_valid_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      res_cluster_in = res_cluster_ff;
      res_status_in  = res_status_ff;
      mem_we         = 1'b0;
      mem_waddr      = scan_ff[AW-1:0];
      mem_wdata      = '0;
      mem_raddr      = req_cluster[AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff[AW-1:0];
            scan_in   = scan_ff + CW'(1);
            if (scan_ff == N_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_raddr      = req_cluster[AW-1:0];
            res_cluster_in = '0;
            res_status_in  = fca_pkg::STAT_OK;
            if (accept) begin
               prev_in = req_cluster;
               cur_in  = req_cluster;
               case (req_func)
                  fca_pkg::FUNC_ALLOC: begin
                     scan_in      = CW'(2);
                     chk_valid_in = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  fca_pkg::FUNC_FREE: begin
                     state_in = ST_WALK_CHK;
                  end
                  fca_pkg::FUNC_WRITE: begin
                     if (req_cluster < N_CL) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_cluster[AW-1:0];
                        mem_wdata = req_entry_value;
                     end else begin
                        res_status_in = fca_pkg::STAT_IO;
                     end
                     state_in = ST_RESULT;
                  end
                  default: begin
                     if (req_cluster < N_CL) begin
                        state_in = ST_RD_WAIT;
                     end else begin
                        res_status_in = fca_pkg::STAT_IO;
                        state_in      = ST_RESULT;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // entry chk_ff arrives while entry scan_ff is fetched
            mem_raddr = scan_ff[AW-1:0];
            if (chk_valid_ff && (mem_rdata == '0)) begin
               if (link_req && (prev_ff >= N_CL)) begin
                  // link would fail: net effect leaves the table untouched
                  res_status_in = fca_pkg::STAT_IO;
                  state_in      = ST_RESULT;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = chk_ff[AW-1:0];
                  mem_wdata = cfg.end_of_chain_value;
                  if (link_req) begin
                     state_in = ST_LINK;
                  end else begin
                     res_cluster_in = fca_pkg::CLUSTER_W'(chk_ff);
                     state_in       = ST_RESULT;
                  end
               end
            end else if (scan_ff > last) begin
               res_status_in = fca_pkg::STAT_NO_FREE;
               state_in      = ST_RESULT;
            end else if (scan_ff >= N_CW) begin
               res_status_in = fca_pkg::STAT_IO;
               state_in      = ST_RESULT;
            end else begin
               chk_in       = scan_ff;
               chk_valid_in = 1'b1;
               scan_in      = scan_ff + CW'(1);
            end
         end
         ST_LINK: begin
            mem_we         = 1'b1;
            mem_waddr      = prev_ff[AW-1:0];
            mem_wdata      = fca_pkg::CLUSTER_W'(chk_ff);
            res_cluster_in = fca_pkg::CLUSTER_W'(chk_ff);
            state_in       = ST_RESULT;
         end
         ST_WALK_CHK: begin
            mem_raddr = cur_ff[AW-1:0];
            if (cur_ff < TWO_CL) begin
               res_status_in = fca_pkg::STAT_INVALID;
               state_in      = ST_RESULT;
            end else if (cur_ff >= cfg.end_of_chain_value) begin
               state_in = ST_RESULT;
            end else if (cur_ff >= N_CL) begin
               res_status_in = fca_pkg::STAT_IO;
               state_in      = ST_RESULT;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // free the current entry and fetch the one it links to
            mem_we    = 1'b1;
            mem_waddr = cur_ff[AW-1:0];
            mem_wdata = '0;
            mem_raddr = mem_rdata[AW-1:0];
            cur_in    = mem_rdata;
            if (mem_rdata < TWO_CL) begin
               res_status_in = fca_pkg::STAT_CORRUPT;
               state_in      = ST_RESULT;
            end else if (mem_rdata >= cfg.end_of_chain_value) begin
               state_in = ST_RESULT;
            end else if (mem_rdata >= N_CL) begin
               res_status_in = fca_pkg::STAT_IO;
               state_in      = ST_RESULT;
            end
         end
         ST_RD_WAIT: begin
            res_cluster_in = mem_rdata;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff         <= chk_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      res_cluster_ff <= res_cluster_in;
      res_status_ff  <= res_status_in;
   end

   a_chk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && chk_valid_ff |-> (chk_ff >= CW'(2)) && (chk_ff < N_CW))
      else $error("scan checks an index outside the table");

   a_link_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINK) |-> (prev_ff >= TWO_CL) && (prev_ff < N_CL))
      else $error("link written to a cluster outside the table");

   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cur_ff >= TWO_CL) && (cur_ff < N_CL)
         && (cur_ff < cfg.end_of_chain_value))
      else $error("walk frees an entry it should not reach");

   a_result_handed: assert property (@(posedge clock) disable iff (reset)
      res.valid && res_take |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after hand-over");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && (scan_ff == N_LAST) |=> (state_ff == ST_IDLE))
      else $error("clearing pass overran the table");

endmodule

### sv/fat_cluster_allocator.sv
// Channel  | Ports                                              | Direction
// req      | req_valid, req_stall, req_func, req_cluster,       | in
//          |   req_entry_value                                  |
// rsp      | rsp_valid, rsp_stall, rsp_result_cluster,          | out
//          |   rsp_status                                       |
// csr      | csr_we, csr_index, csr_wdata                       | in, write only
//
// After reset a clearing pass zeroes the table, one entry a cycle; no transaction
// is taken during it (register writes still are).
// One transaction at a time, run by the sequencer as it walks the table.
// The result register lets the next transaction start while a result still
// sits stalled on rsp; a further result waits until it has been taken.
module fat_cluster_allocator #(
   parameter int NUM_CLUSTERS = fca_pkg::NUM_CLUSTERS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fca_pkg::FUNC_W-1:0]          req_func,
   input  logic [fca_pkg::CLUSTER_W-1:0]       req_cluster,
   input  logic [fca_pkg::CLUSTER_W-1:0]       req_entry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fca_pkg::CLUSTER_W-1:0]       rsp_result_cluster,
   output logic [fca_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                csr_we,
   input  logic [fca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fca_pkg::CLUSTER_W-1:0]       csr_wdata
);

   localparam int AW = $clog2(NUM_CLUSTERS);

   // configuration registers
   logic [fca_pkg::DCC_W-1:0]     dcc_ff;
   logic [fca_pkg::CLUSTER_W-1:0] eoc_ff;
   fca_pkg::cfg_type              cfg;

   // result register
   logic                          rsp_valid_ff;
   logic [fca_pkg::CLUSTER_W-1:0] rsp_cluster_ff;
   logic [fca_pkg::STATUS_W-1:0]  rsp_status_ff;

   fca_pkg::res_type              res;
   logic                          res_take;

   logic                          mem_we;
   logic [AW-1:0]                 mem_waddr;
   logic [fca_pkg::CLUSTER_W-1:0] mem_wdata;
   logic [AW-1:0]                 mem_raddr;
   logic [fca_pkg::CLUSTER_W-1:0] mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         dcc_ff <= fca_pkg::DCC_RESET;
         eoc_ff <= fca_pkg::EOC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fca_pkg::CSR_DATA_CLUSTER_COUNT: dcc_ff <= csr_wdata[fca_pkg::DCC_W-1:0];
            fca_pkg::CSR_END_OF_CHAIN:       eoc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.data_cluster_count = dcc_ff;
   assign cfg.end_of_chain_value = eoc_ff;

   // the sequencer hands a result over once the register is empty or draining
   assign res_take = res.valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_cluster_ff <= res.cluster;
         rsp_status_ff  <= res.status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_cluster = rsp_cluster_ff;
   assign rsp_status         = rsp_status_ff;

   fca_ctrl #(
      .NUM_CLUSTERS (NUM_CLUSTERS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_cluster     (req_cluster),
      .req_entry_value (req_entry_value),
      .cfg             (cfg),
      .res             (res),
      .res_take        (res_take),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata)
   );

   fca_ram #(
      .DEPTH (NUM_CLUSTERS)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

### tb/sv/fat_cluster_allocator_test.sv
module fat_cluster_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fca_pkg::*;

   // Table depth of the instance (default parameter) and widest cluster value.
   localparam int                   TABLE_DEPTH = NUM_CLUSTERS_DEFAULT;
   localparam logic [CLUSTER_W-1:0] CLUSTER_MAX = '1;

   // Longest quiet spell is a full-table scan or walk or the clearing pass
   // after reset; the limit is that several times over.
   localparam int WATCHDOG_LIMIT   = 50000;
   localparam int HOLD_OFF_STRETCH = 300;
   localparam int END_SETTLE       = 16;
   localparam int RANDOM_PER_PHASE = 18;
   localparam int EXHAUST_COUNT    = 8;

   // One reply as the block should give it.
   typedef struct packed {
      logic [CLUSTER_W-1:0] cluster;
      logic [STATUS_W-1:0]  status;
   } table_reply_type;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func        = FUNC_READ;
   logic [CLUSTER_W-1:0] req_cluster     = '0;
   logic [CLUSTER_W-1:0] req_entry_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [CLUSTER_W-1:0] rsp_result_cluster;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = CSR_DATA_CLUSTER_COUNT;
   logic [CLUSTER_W-1:0] csr_wdata       = '0;

   // Shadow copy of the table and registers, advanced as each transaction is taken.
   logic [CLUSTER_W-1:0] shadow_fat [TABLE_DEPTH];
   logic [DCC_W-1:0]     shadow_dcc = DCC_RESET;
   logic [CLUSTER_W-1:0] shadow_eoc = EOC_RESET;

   table_reply_type pending_replies [$];
   table_reply_type oldest_reply;

   int failures           = 0;
   int idle_cycles        = 0;
   int sender_max_gap     = 8;
   int receiver_max_stall = 8;
   int hold_off_cycles    = 0;

   fat_cluster_allocator u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_cluster        (req_cluster),
      .req_entry_value    (req_entry_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_cluster (rsp_result_cluster),
      .rsp_status         (rsp_status),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow table: applies one transaction and returns the reply due.
   // ------------------------------------------------------------------
   function automatic table_reply_type apply_table_op(input logic [FUNC_W-1:0] func,
                                                      input logic [CLUSTER_W-1:0] cl,
                                                      input logic [CLUSTER_W-1:0] val);
      table_reply_type      reply;
      int                   last;
      int                   c;
      int                   found;
      int                   guard;
      logic [CLUSTER_W-1:0] cur;
      logic [CLUSTER_W-1:0] nxt;
      logic                 walking;
      reply.cluster = '0;
      reply.status  = STAT_OK;
      case (func)
         FUNC_ALLOC: begin
            // first-fit search over 2 .. count+1; may run off the table
            last  = shadow_dcc + 1;
            found = 0;
            for (c = 2; c <= last && found == 0 && reply.status == STAT_OK; c++) begin
               if (c >= TABLE_DEPTH)
                  reply.status = STAT_IO;
               else if (shadow_fat[c] == '0)
                  found = c;
            end
            if (reply.status == STAT_OK) begin
               if (found == 0)
                  reply.status = STAT_NO_FREE;
               else if (cl >= 2 && cl >= TABLE_DEPTH)
                  reply.status = STAT_IO;  // link fails, new entry stays free
               else begin
                  shadow_fat[found] = shadow_eoc;
                  if (cl >= 2)
                     shadow_fat[cl] = CLUSTER_W'(found);
                  reply.cluster = CLUSTER_W'(found);
               end
            end
         end
         FUNC_FREE: begin
            if (cl < 2)
               reply.status = STAT_INVALID;
            else begin
               cur          = cl;
               walking      = 1'b1;
               reply.status = STAT_CORRUPT;  // stands if the walk never ends
               for (guard = 0; guard <= TABLE_DEPTH && walking; guard++) begin
                  if (cur < 2 || cur >= shadow_eoc) begin
                     reply.status = STAT_OK;
                     walking      = 1'b0;
                  end else if (cur >= TABLE_DEPTH) begin
                     reply.status = STAT_IO;
                     walking      = 1'b0;
                  end else begin
                     nxt             = shadow_fat[cur];
                     shadow_fat[cur] = '0;
                     cur             = nxt;
                     if (cur < 2) begin
                        reply.status = STAT_CORRUPT;
                        walking      = 1'b0;
                     end
                  end
               end
            end
         end
         FUNC_WRITE: begin
            if (cl < TABLE_DEPTH)
               shadow_fat[cl] = val;
            else
               reply.status = STAT_IO;
         end
         default: begin
            if (cl < TABLE_DEPTH)
               reply.cluster = shadow_fat[cl];
            else
               reply.status = STAT_IO;
         end
      endcase
      return reply;
   endfunction

   function automatic logic [CLUSTER_W-1:0] random_word();
      return CLUSTER_W'($urandom);
   endfunction

   // ------------------------------------------------------------------
   // Request side: random gap, then hold the transaction until taken.
   // Valid is only lowered when a gap is drawn, so back-to-back
   // transactions never see valid dropped and raised in one step.
   // ------------------------------------------------------------------
   task automatic send_op(input logic [FUNC_W-1:0] func, input logic [CLUSTER_W-1:0] cl,
                          input logic [CLUSTER_W-1:0] val, output table_reply_type reply);
      int gap;
      gap = $urandom_range(0, sender_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_cluster     <= cl;
      req_entry_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      reply = apply_table_op(func, cl, val);
      pending_replies.push_back(reply);
   endtask

   // Stop offering and wait until every reply has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register writes only with the block idle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CLUSTER_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_DATA_CLUSTER_COUNT)
         shadow_dcc = value[DCC_W-1:0];
      else
         shadow_eoc = value;
   endtask

   // ------------------------------------------------------------------
   // Response side: per-transaction stall of random length up to
   // receiver_max_stall, or a long hold-off when a test asks for one.
   // ------------------------------------------------------------------
   initial begin : result_sink
      int wait_cycles;
      forever begin
         if (hold_off_cycles > 0) begin
            wait_cycles     = hold_off_cycles;
            hold_off_cycles = 0;
         end else
            wait_cycles = $urandom_range(0, receiver_max_stall);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic note_mismatch(input string what, input logic [CLUSTER_W-1:0] want,
                                input logic [CLUSTER_W-1:0] got);
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
   endtask

   // Each reply taken is checked against the oldest one outstanding.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            failures++;
            $display("%0t: unexpected transaction, expected none, actual %0h/%0h",
                     $time, rsp_result_cluster, rsp_status);
         end else begin
            oldest_reply = pending_replies.pop_front();
            if (rsp_result_cluster !== oldest_reply.cluster)
               note_mismatch("result_cluster", oldest_reply.cluster, rsp_result_cluster);
            if (rsp_status !== oldest_reply.status)
               note_mismatch("status", CLUSTER_W'(oldest_reply.status),
                             CLUSTER_W'(rsp_status));
         end
      end
   end

   // Watchdog: cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reads and writes at the table edges, indices 0 and 1 included.
   task automatic test_direct_access();
      table_reply_type r;
      send_op(FUNC_READ, 28'd0, CLUSTER_MAX, r);
      send_op(FUNC_READ, CLUSTER_W'(TABLE_DEPTH - 1), 28'd0, r);
      send_op(FUNC_READ, CLUSTER_W'(TABLE_DEPTH), 28'd0, r);   // just past the table
      send_op(FUNC_WRITE, CLUSTER_MAX, CLUSTER_MAX, r);        // far past the table
      send_op(FUNC_WRITE, 28'd0, CLUSTER_MAX, r);
      send_op(FUNC_READ, 28'd0, 28'd0, r);
      send_op(FUNC_WRITE, 28'd1, 28'd0, r);
      send_op(FUNC_READ, 28'd1, CLUSTER_MAX, r);
      drain();
   endtask

   // Allocate and free-chain corner cases at reset register values.
   task automatic test_allocate_and_free_cases();
      table_reply_type r;
      send_op(FUNC_ALLOC, 28'd0, 28'd0, r);                     // new chain at 2
      send_op(FUNC_ALLOC, 28'd2, 28'd0, r);                     // 2 -> 3
      send_op(FUNC_ALLOC, 28'd1, 28'd0, r);                     // prev 1: no link
      send_op(FUNC_ALLOC, CLUSTER_W'(TABLE_DEPTH), 28'd0, r);   // link off the table
      send_op(FUNC_ALLOC, CLUSTER_MAX, 28'd0, r);
      send_op(FUNC_FREE, 28'd0, 28'd0, r);                      // invalid starts
      send_op(FUNC_FREE, 28'd1, 28'd0, r);
      send_op(FUNC_FREE, 28'd2, 28'd0, r);                      // well-formed chain
      send_op(FUNC_FREE, CLUSTER_MAX, 28'd0, r);                // start above the marker
      send_op(FUNC_FREE, CLUSTER_W'(TABLE_DEPTH), 28'd0, r);    // start past the table
      // link to 1 ends the walk as corruption
      send_op(FUNC_WRITE, 28'd6, 28'd7, r);
      send_op(FUNC_WRITE, 28'd7, 28'd1, r);
      send_op(FUNC_FREE, 28'd6, 28'd0, r);
      // two-entry loop
      send_op(FUNC_WRITE, 28'd8, 28'd9, r);
      send_op(FUNC_WRITE, 28'd9, 28'd8, r);
      send_op(FUNC_FREE, 28'd8, 28'd0, r);
      // link walks off the table below the marker
      send_op(FUNC_WRITE, 28'd10, CLUSTER_W'(TABLE_DEPTH), r);
      send_op(FUNC_FREE, 28'd10, 28'd0, r);
      send_op(FUNC_READ, 28'd4, 28'd0, r);
      drain();
   endtask

   // Register extremes, each followed by transactions that depend on it.
   task automatic test_register_extremes();
      table_reply_type r;
      send_op(FUNC_FREE, 28'd4, 28'd0, r);                 // clear what is left
      write_register(CSR_DATA_CLUSTER_COUNT, 28'd0);
      send_op(FUNC_ALLOC, 28'd0, 28'd0, r);                // empty search range
      write_register(CSR_DATA_CLUSTER_COUNT, 28'd1);
      send_op(FUNC_ALLOC, 28'd0, 28'd0, r);
      send_op(FUNC_ALLOC, 28'd0, 28'd0, r);                // range full
      send_op(FUNC_FREE, 28'd2, 28'd0, r);
      write_register(CSR_END_OF_CHAIN, 28'd2);
      send_op(FUNC_ALLOC, 28'd0, 28'd0, r);                // marker written as 2
      send_op(FUNC_FREE, 28'd2, 28'd0, r);                 // start at the marker
      send_op(FUNC_READ, 28'd2, 28'd0, r);
      write_register(CSR_END_OF_CHAIN, CLUSTER_MAX);
      send_op(FUNC_WRITE, 28'd20, 28'd21, r);
      send_op(FUNC_WRITE, 28'd21, CLUSTER_MAX, r);
      send_op(FUNC_FREE, 28'd20, 28'd0, r);
      send_op(FUNC_READ, 28'd21, 28'd0, r);
      send_op(FUNC_WRITE, 28'd2, 28'd0, r);
      write_register(CSR_DATA_CLUSTER_COUNT, CLUSTER_W'(DCC_RESET));
      write_register(CSR_END_OF_CHAIN, EOC_RESET);
   endtask

   // Mostly chain building and freeing with random content, some loose
   // reads and writes, some noise over the whole field ranges.
   task automatic test_random_traffic();
      table_reply_type      r;
      logic [CLUSTER_W-1:0] heads [$];
      logic [CLUSTER_W-1:0] tail;
      logic [CLUSTER_W-1:0] prev;
      logic [CLUSTER_W-1:0] v;
      int                   phase;
      int                   k;
      int                   pick;
      int                   idx;
      tail = '0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_DATA_CLUSTER_COUNT, CLUSTER_W'($urandom_range(8, 64)));
               write_register(CSR_END_OF_CHAIN, EOC_RESET);
            end
            1: begin
               write_register(CSR_DATA_CLUSTER_COUNT, CLUSTER_W'(DCC_RESET));
               write_register(CSR_END_OF_CHAIN,
                              CLUSTER_W'($urandom_range(64, CLUSTER_MAX)));
            end
            2: begin
               // no idling on either side here
               write_register(CSR_DATA_CLUSTER_COUNT, CLUSTER_W'($urandom_range(1, 12)));
               write_register(CSR_END_OF_CHAIN, CLUSTER_W'($urandom_range(16, 80)));
               sender_max_gap     = 0;
               receiver_max_stall = 0;
            end
            default: begin
               write_register(CSR_DATA_CLUSTER_COUNT,
                              CLUSTER_W'($urandom_range(1, DCC_RESET)));
               write_register(CSR_END_OF_CHAIN, CLUSTER_MAX);
               sender_max_gap     = 8;
               receiver_max_stall = 8;
            end
         endcase
         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               if (heads.size() == 0 || $urandom_range(0, 3) == 0)
                  prev = CLUSTER_W'($urandom_range(0, 1));
               else
                  prev = tail;
               send_op(FUNC_ALLOC, prev, random_word(), r);
               if (r.status == STAT_OK) begin
                  if (prev < 2)
                     heads.push_back(r.cluster);
                  tail = r.cluster;
               end
            end else if (pick < 45 && heads.size() != 0) begin
               idx = $urandom_range(0, heads.size() - 1);
               send_op(FUNC_FREE, heads[idx], random_word(), r);
               heads.delete(idx);
            end else if (pick < 60) begin
               if ($urandom_range(0, 7) == 0)
                  send_op(FUNC_READ, CLUSTER_W'($urandom_range(0, TABLE_DEPTH - 1)),
                          random_word(), r);
               else
                  send_op(FUNC_READ, CLUSTER_W'($urandom_range(0, 63)), random_word(), r);
            end else if (pick < 75) begin
               case ($urandom_range(0, 3))
                  0:       v = '0;
                  1:       v = CLUSTER_W'($urandom_range(2, 63));
                  2:       v = shadow_eoc;
                  default: v = random_word();
               endcase
               send_op(FUNC_WRITE, CLUSTER_W'($urandom_range(0, 63)), v, r);
            end else if (pick < 85)
               send_op(FUNC_FREE, CLUSTER_W'($urandom_range(0, 63)), random_word(), r);
            else
               send_op(FUNC_W'($urandom_range(0, 3)), random_word(), random_word(), r);
         end
      end
      drain();
   endtask

   // Receiver holds off for a long stretch while the sender keeps going,
   // so the block fills and pushes back on the request side.
   task automatic test_result_backpressure();
      table_reply_type r;
      int              k;
      sender_max_gap  = 0;
      hold_off_cycles = HOLD_OFF_STRETCH;
      for (k = 0; k < 16; k++) begin
         if (k[0])
            send_op(FUNC_READ, CLUSTER_W'(32 + k), random_word(), r);
         else
            send_op(FUNC_WRITE, CLUSTER_W'(33 + k), random_word(), r);
      end
      sender_max_gap = 8;
      drain();
   endtask

   // Fill every data cluster of a short search range, search it full,
   // then free its last cluster and find that one.
   task automatic test_table_exhaustion();
      table_reply_type      r;
      logic [CLUSTER_W-1:0] v;
      int                   c;
      write_register(CSR_DATA_CLUSTER_COUNT, CLUSTER_W'(EXHAUST_COUNT));
      sender_max_gap     = 0;
      receiver_max_stall = 0;
      for (c = 2; c <= EXHAUST_COUNT + 1; c++) begin
         v = random_word();
         if (v == '0)
            v = 28'd1;
         send_op(FUNC_WRITE, CLUSTER_W'(c), v, r);
      end
      sender_max_gap     = 8;
      receiver_max_stall = 8;
      send_op(FUNC_ALLOC, 28'd0, 28'd0, r);                           // no free cluster
      send_op(FUNC_WRITE, CLUSTER_W'(EXHAUST_COUNT + 1), 28'd0, r);
      send_op(FUNC_ALLOC, 28'd1, 28'd0, r);                           // last cluster found
      send_op(FUNC_READ, CLUSTER_W'(EXHAUST_COUNT + 1), 28'd0, r);
      drain();
   endtask

   initial begin : stimulus
      for (int i = 0; i < TABLE_DEPTH; i++)
         shadow_fat[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_direct_access();
      test_allocate_and_free_cases();
      test_register_extremes();
      test_random_traffic();
      test_result_backpressure();
      test_table_exhaustion();

      drain();
      repeat (END_SETTLE) @(posedge clock);
      if (failures == 0 && pending_replies.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
